### rtl/core/mac_byte_count_table_unit_defines.svh
// Assertion macros for the MAC byte count table RTL.
`ifndef MAC_BYTE_COUNT_TABLE_UNIT_DEFINES_SVH
`define MAC_BYTE_COUNT_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MBCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MBCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/mbct_pkg.sv
// Types and constants for the MAC byte count table.
`timescale 1ns / 1ps
`default_nettype none

package mbct_pkg;

  localparam int unsigned MAC_W        = 48;
  localparam int unsigned TOTAL_W      = 32;
  localparam int unsigned LEN_W        = 16;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned PREFIX_SHIFT = 24;
  localparam int unsigned IN_TDATA_W   = 120;
  localparam int unsigned OUT_TDATA_W  = 104;

  localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

  // Configuration register indexes
  localparam logic REG_KEY_SELECT  = 1'b0;
  localparam logic REG_PREFIX_MODE = 1'b1;

  typedef enum logic [1:0] {
    OP_PACKET = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FINISH
  } state_e;

  // Input word, first member is the top bits
  typedef struct packed {
    logic [IDX_W-1:0] read_index;
    logic [LEN_W-1:0] packet_length;
    logic [MAC_W-1:0] receiver_mac;
    logic [MAC_W-1:0] transmitter_mac;
    op_e              op;
  } in_word_t;

  // Result word, padded to whole bytes at the top
  typedef struct packed {
    logic [6:0]         pad;
    logic               table_full;
    logic               dropped_broadcast;
    logic               was_new;
    logic               entry_valid;
    logic [COUNT_W-1:0] entry_count;
    logic [TOTAL_W-1:0] total_bytes;
    logic [MAC_W-1:0]   entry_key;
    logic [IDX_W-1:0]   entry_index;
  } out_word_t;

endpackage

`default_nettype wire

### rtl/core/mbct_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module mbct_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/core/mac_byte_count_table_unit.sv
// MAC byte count table: per-key running byte totals kept in RAM, searched linearly.
// Each packet record (op 0) is checked for a broadcast address, keyed by the
// transmitter or receiver address (optionally cut to the 24-bit vendor prefix)
// and searched for in the table one entry at a time: each entry takes a read
// state for the RAM read and then a compare state for the 48-bit compare and
// saturating add. A record that hits stops at the matching entry; one that
// misses after comparing all used entries appends the key, or is refused when
// the table is full. A read of a used entry (op 1) goes through the read and
// compare states; a read past the used entries, clear, broadcast and op 3 go
// straight to the finish state. The key and total RAM read port sets the
// search rate. The result sits in an output register; while an earlier result
// still waits there, the block holds in its finish state, and the next word
// is taken once the current one has moved into it.
`timescale 1ns / 1ps
`default_nettype none

`include "mac_byte_count_table_unit_defines.svh"

module mac_byte_count_table_unit #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_index_i,
  input  wire logic                                cfg_data_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // op, transmitter_mac, receiver_mac, packet_length, read_index
  input  wire logic [mbct_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // entry_index, entry_key, total_bytes, entry_count, entry_valid, was_new,
  // dropped_broadcast, table_full, zero pad
  output logic      [mbct_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > mbct_pkg::IDX_W) ? CNT_W : mbct_pkg::IDX_W;

  mbct_pkg::state_e    state_q, state_d;
  mbct_pkg::op_e       op_q, op_d;
  mbct_pkg::in_word_t  in_word;
  mbct_pkg::out_word_t res_q, res_d;
  mbct_pkg::out_word_t out_q, out_d;

  logic                          key_select_q, prefix_mode_q;
  logic [mbct_pkg::MAC_W-1:0]    key_q, key_d;
  logic [mbct_pkg::LEN_W-1:0]    len_q, len_d;
  logic [CNT_W-1:0]              idx_q, idx_d;
  logic [CNT_W-1:0]              used_q, used_d;
  logic                          out_valid_q, out_valid_d;

  logic                          in_accept;
  logic                          is_bcast;
  logic                          in_range;
  logic                          at_end;
  logic                          is_full;
  logic                          key_hit;
  logic [mbct_pkg::MAC_W-1:0]    sel_mac;
  logic [mbct_pkg::MAC_W-1:0]    new_key;
  logic [mbct_pkg::TOTAL_W:0]    sum_wide;
  logic [mbct_pkg::TOTAL_W-1:0]  sum_sat;

  logic                          key_we, total_we;
  logic [AW-1:0]                 waddr;
  logic [mbct_pkg::TOTAL_W-1:0]  total_wdata;
  logic [mbct_pkg::MAC_W-1:0]    key_rdata;
  logic [mbct_pkg::TOTAL_W-1:0]  total_rdata;

  assign in_word   = mbct_pkg::in_word_t'(s_axis_tdata);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign is_bcast = (in_word.transmitter_mac == mbct_pkg::BCAST_MAC) ||
                    (in_word.receiver_mac == mbct_pkg::BCAST_MAC);
  assign sel_mac  = key_select_q ? in_word.receiver_mac : in_word.transmitter_mac;
  assign new_key  = prefix_mode_q ? (sel_mac >> mbct_pkg::PREFIX_SHIFT) : sel_mac;
  assign in_range = CMP_W'(in_word.read_index) < CMP_W'(used_q);

  assign at_end   = (idx_q == used_q);
  assign is_full  = (used_q == CNT_W'(TABLE_DEPTH));
  assign key_hit  = (key_rdata == key_q);
  assign sum_wide = {1'b0, total_rdata} + (mbct_pkg::TOTAL_W + 1)'(len_q);
  assign sum_sat  = sum_wide[mbct_pkg::TOTAL_W] ? {mbct_pkg::TOTAL_W{1'b1}}
                                                : sum_wide[mbct_pkg::TOTAL_W-1:0];

  mbct_ram #(
    .WIDTH (mbct_pkg::MAC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (key_q),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (key_rdata)
  );

  mbct_ram #(
    .WIDTH (mbct_pkg::TOTAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_total_ram (
    .clk_i   (clk_i),
    .we_i    (total_we),
    .waddr_i (waddr),
    .wdata_i (total_wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (total_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mbct_pkg::ST_IDLE: begin
        if (in_accept) begin
          if ((in_word.op == mbct_pkg::OP_PACKET && !is_bcast) ||
              (in_word.op == mbct_pkg::OP_READ && in_range)) begin
            state_d = mbct_pkg::ST_READ;
          end else begin
            state_d = mbct_pkg::ST_FINISH;
          end
        end
      end
      mbct_pkg::ST_READ: begin
        if (op_q == mbct_pkg::OP_PACKET && at_end) begin
          state_d = mbct_pkg::ST_FINISH;
        end else begin
          state_d = mbct_pkg::ST_CMP;
        end
      end
      mbct_pkg::ST_CMP: begin
        if (op_q == mbct_pkg::OP_PACKET && !key_hit) begin
          state_d = mbct_pkg::ST_READ;
        end else begin
          state_d = mbct_pkg::ST_FINISH;
        end
      end
      mbct_pkg::ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = mbct_pkg::ST_IDLE;
        end
      end
      default: state_d = mbct_pkg::ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    len_d       = len_q;
    idx_d       = idx_q;
    used_d      = used_q;
    res_d       = res_q;
    key_we      = 1'b0;
    total_we    = 1'b0;
    waddr       = idx_q[AW-1:0];
    total_wdata = sum_sat;
    s_axis_tready = (state_q == mbct_pkg::ST_IDLE);

    case (state_q)
      mbct_pkg::ST_IDLE: begin
        if (in_accept) begin
          op_d  = in_word.op;
          key_d = new_key;
          len_d = in_word.packet_length;
          idx_d = '0;
          res_d = '0;
          case (in_word.op)
            mbct_pkg::OP_PACKET: begin
              res_d.dropped_broadcast = is_bcast;
            end
            mbct_pkg::OP_READ: begin
              idx_d             = CNT_W'(in_word.read_index);
              res_d.entry_index = in_word.read_index;
            end
            mbct_pkg::OP_CLEAR: begin
              used_d = '0;
            end
            default: ;
          endcase
        end
      end
      mbct_pkg::ST_READ: begin
        // End of used entries: append the key or refuse it
        if (op_q == mbct_pkg::OP_PACKET && at_end) begin
          res_d           = '0;
          res_d.entry_key = key_q;
          if (is_full) begin
            res_d.table_full = 1'b1;
          end else begin
            key_we            = 1'b1;
            total_we          = 1'b1;
            waddr             = used_q[AW-1:0];
            total_wdata       = mbct_pkg::TOTAL_W'(len_q);
            used_d            = used_q + 1'b1;
            res_d.entry_index = mbct_pkg::IDX_W'(used_q);
            res_d.total_bytes = mbct_pkg::TOTAL_W'(len_q);
            res_d.entry_valid = 1'b1;
            res_d.was_new     = 1'b1;
          end
        end
      end
      mbct_pkg::ST_CMP: begin
        res_d             = '0;
        res_d.entry_index = mbct_pkg::IDX_W'(idx_q);
        res_d.entry_valid = 1'b1;
        if (op_q == mbct_pkg::OP_PACKET) begin
          if (key_hit) begin
            total_we          = 1'b1;
            res_d.entry_key   = key_q;
            res_d.total_bytes = sum_sat;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          res_d.entry_key   = key_rdata;
          res_d.total_bytes = total_rdata;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == mbct_pkg::ST_FINISH && (!out_valid_q || m_axis_tready)) begin
      out_valid_d       = 1'b1;
      out_d             = res_q;
      out_d.entry_count = mbct_pkg::COUNT_W'(used_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= mbct_pkg::ST_IDLE;
      used_q        <= '0;
      out_valid_q   <= 1'b0;
      key_select_q  <= 1'b0;
      prefix_mode_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          mbct_pkg::REG_KEY_SELECT:  key_select_q  <= cfg_data_i;
          mbct_pkg::REG_PREFIX_MODE: prefix_mode_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    key_q <= key_d;
    len_q <= len_d;
    idx_q <= idx_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  `MBCT_ASSERT_IMP(a_used_bound, 1'b1, used_q <= CNT_W'(TABLE_DEPTH), "used count beyond table depth")
  `MBCT_ASSERT_NEXT(a_accept_busy, in_accept, state_q != mbct_pkg::ST_IDLE, "idle after accepting a word")
  `MBCT_ASSERT_IMP(a_search_in_use, state_q == mbct_pkg::ST_CMP, idx_q < used_q, "compare on an unused entry")
  `MBCT_ASSERT_NEXT(a_out_from_finish, state_q != mbct_pkg::ST_FINISH && !out_valid_q, !out_valid_q, "result shown without finish")

endmodule

`default_nettype wire
